>>> rtl/stq_pkg.sv
package stq_pkg;

  // Control word that travels with every item along the chain.
  typedef struct packed {
    logic valid;       // slot carries an item
    logic is_query;    // 1 for a query, 0 for an insert
    logic empty;       // table held no entries when the query was taken
    logic overflowed;  // an insert was dropped since the previous query
    logic saturated;   // this query clamped the running total
  } stq_ctl_t;

endpackage

>>> rtl/stq_front.sv
module stq_front #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   in_valid_i,
  input  logic                   req_type_i,
  input  logic [VALUE_WIDTH-1:0] operand_i,
  output stq_pkg::stq_ctl_t      ctl_o,
  output logic [VALUE_WIDTH+1:0] a_o,
  output logic [VALUE_WIDTH+2:0] nt_o,
  output logic [VALUE_WIDTH+1:0] best_o
);
  import stq_pkg::*;

  localparam int TW = VALUE_WIDTH + 2;
  localparam int NW = VALUE_WIDTH + 3;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TW-1:0] TMAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic [TW-1:0] TMIN = {1'b1, {(TW-1){1'b0}}};

  logic [CW-1:0] count_q;
  logic [TW-1:0] total_q;
  logic          drop_q;
  logic          accept;
  logic          tab_full;
  logic [NW-1:0] sum;
  logic          sat;
  logic [TW-1:0] t_new;
  logic [TW-1:0] op_ext;

  stq_ctl_t      ctl1_q;
  logic [TW-1:0] a1_q;
  stq_ctl_t      ctl2_q;
  logic [TW-1:0] a2_q;
  logic [NW-1:0] nt2_q;
  logic [TW-1:0] best2_q;

  assign accept   = in_valid_i & adv_i;
  assign tab_full = (count_q == CW'(TABLE_DEPTH));
  assign op_ext   = {{2{operand_i[VALUE_WIDTH-1]}}, operand_i};

  // Saturating update of the running total; overflow shows in the top two bits.
  assign sum   = {total_q[TW-1], total_q} + {op_ext[TW-1], op_ext};
  assign sat   = sum[NW-1] ^ sum[NW-2];
  assign t_new = sat ? (sum[NW-1] ? TMIN : TMAX) : sum[TW-1:0];

  // Table fill count, running total and dropped-insert flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
      drop_q  <= 1'b0;
    end else if (accept) begin
      if (req_type_i) begin
        total_q <= t_new;
        drop_q  <= 1'b0;
      end else if (tab_full) begin
        drop_q  <= 1'b1;
      end else begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // Control of the two entry stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (adv_i) begin
      ctl1_q.valid      <= accept & (req_type_i | ~tab_full);
      ctl1_q.is_query   <= req_type_i;
      ctl1_q.empty      <= (count_q == '0);
      ctl1_q.overflowed <= drop_q;
      ctl1_q.saturated  <= req_type_i & sat;
      ctl2_q            <= ctl1_q;
    end
  end

  // Payload of the entry stages; the second one prepares the negated total.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q    <= req_type_i ? t_new : op_ext;
      a2_q    <= a1_q;
      nt2_q   <= NW'(0) - {a1_q[TW-1], a1_q};
      best2_q <= '1;
    end
  end

  assign ctl_o  = ctl2_q;
  assign a_o    = a2_q;
  assign nt_o   = nt2_q;
  assign best_o = best2_q;

endmodule

>>> rtl/stq_cell.sv
module stq_cell #(
  parameter int VALUE_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  stq_pkg::stq_ctl_t      ctl_i,
  input  logic [VALUE_WIDTH+1:0] a_i,
  input  logic [VALUE_WIDTH+2:0] nt_i,
  input  logic [VALUE_WIDTH+1:0] best_i,
  output stq_pkg::stq_ctl_t      ctl_o,
  output logic [VALUE_WIDTH+1:0] a_o,
  output logic [VALUE_WIDTH+2:0] nt_o,
  output logic [VALUE_WIDTH+1:0] best_o
);
  import stq_pkg::*;

  localparam int TW = VALUE_WIDTH + 2;
  localparam int NW = VALUE_WIDTH + 3;

  logic                          full_q;
  logic                          full_d;
  logic signed [VALUE_WIDTH-1:0] val_q;
  logic signed [VALUE_WIDTH-1:0] val_d;
  logic signed [VALUE_WIDTH-1:0] in_val;
  logic [NW-1:0]                 e_ext;
  logic [NW-1:0]                 dpos;
  logic [NW-1:0]                 dneg;
  logic [TW-1:0]                 mag;
  logic                          is_ins;
  logic                          is_qry;

  stq_ctl_t      ctl_q, ctl_d;
  logic [TW-1:0] a_q, a_d;
  logic [NW-1:0] nt_q;
  logic [TW-1:0] best_q, best_d;

  assign in_val = $signed(a_i[VALUE_WIDTH-1:0]);
  assign is_ins = ctl_i.valid & ~ctl_i.is_query;
  assign is_qry = ctl_i.valid & ctl_i.is_query;

  // Distance of the stored entry from the query total, both signs worked in parallel.
  assign e_ext = {{3{val_q[VALUE_WIDTH-1]}}, val_q};
  assign dpos  = {a_i[TW-1], a_i} + e_ext;
  assign dneg  = nt_i - e_ext;
  assign mag   = dpos[NW-1] ? dneg[TW-1:0] : dpos[TW-1:0];

  // An insert settles in an empty cell or swaps with a larger entry and carries it on.
  always_comb begin
    ctl_d  = ctl_i;
    a_d    = a_i;
    best_d = best_i;
    val_d  = val_q;
    full_d = full_q;
    if (is_ins) begin
      if (!full_q) begin
        val_d       = in_val;
        full_d      = 1'b1;
        ctl_d.valid = 1'b0;
      end else if (val_q > in_val) begin
        val_d = in_val;
        a_d   = {{2{val_q[VALUE_WIDTH-1]}}, val_q};
      end
    end
    if (is_qry && full_q && (mag < best_i)) begin
      best_d = mag;
    end
  end

  // Control state of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      ctl_q  <= '0;
    end else if (adv_i) begin
      full_q <= full_d;
      ctl_q  <= ctl_d;
    end
  end

  // Stored entry and the payload handed to the next cell.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q  <= val_d;
      a_q    <= a_d;
      nt_q   <= nt_i;
      best_q <= best_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign a_o    = a_q;
  assign nt_o   = nt_q;
  assign best_o = best_q;

endmodule

>>> rtl/stq_out.sv
module stq_out #(
  parameter int VALUE_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stq_pkg::stq_ctl_t      ctl_i,
  input  logic [VALUE_WIDTH+1:0] best_i,
  input  logic                   ready_i,
  output logic                   adv_o,
  output logic                   valid_o,
  output logic [VALUE_WIDTH:0]   distance_o,
  output logic                   empty_o,
  output logic                   overflowed_o,
  output logic                   saturated_o
);
  import stq_pkg::*;

  logic                 valid_q;
  logic                 last_qry;
  logic [VALUE_WIDTH:0] dist_d;
  logic [VALUE_WIDTH:0] dist_q;
  logic                 empty_q;
  logic                 ovf_q;
  logic                 sat_q;

  // The chain holds only while a result waits and another query is due to land.
  assign last_qry = ctl_i.valid & ctl_i.is_query;
  assign adv_o    = ~valid_q | ready_i | ~last_qry;

  // Empty table reads as zero; a distance beyond the field clamps to all ones.
  always_comb begin
    if (ctl_i.empty) begin
      dist_d = '0;
    end else if (best_i[VALUE_WIDTH+1]) begin
      dist_d = '1;
    end else begin
      dist_d = best_i[VALUE_WIDTH:0];
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o && last_qry) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (adv_o && last_qry) begin
      dist_q  <= dist_d;
      empty_q <= ctl_i.empty;
      ovf_q   <= ctl_i.overflowed;
      sat_q   <= ctl_i.saturated;
    end
  end

  assign valid_o      = valid_q;
  assign distance_o   = dist_q;
  assign empty_o      = empty_q;
  assign overflowed_o = ovf_q;
  assign saturated_o  = sat_q;

endmodule

>>> rtl/sorted_table_nearest_value_query.sv
// Nearest-value query over a sorted table of signed candidates.
//
// Input items arrive on the s_axis channel: tuser selects the kind (0 inserts the
// value in tdata, 1 adds tdata as a signed delta to the running total and queries).
// Each query gives one result item on m_axis: the least |total + entry| over the
// table, with flags for an empty table, a dropped insert and a clamped total.
// Inserts give no result; an insert into a full table is dropped.
//
// The table lives in a row of TABLE_DEPTH cells, each holding one entry. Every
// item moves one cell per cycle while the row advances; a query passes the two
// entry stages, every cell of the row and then the output register. Items
// follow each other in consecutive cycles, so while the row is not held the
// block sustains one item per cycle; the length of the cell row sets the latency.
//
// After reset the table is empty, the total is zero and no flag is pending; no
// clearing pass is needed. When the receiver stalls with a result waiting, the
// whole row holds only once the next query reaches its end, and s_axis_tready
// drops with it.
module sorted_table_nearest_value_query #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 48
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // operand
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
  // req_type
  input  logic                                     s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // distance
  output logic [((VALUE_WIDTH+8)/8)*8-1:0]         m_axis_tdata,
  // table_empty, overflowed, total_saturated
  output logic [2:0]                               m_axis_tuser
);
  import stq_pkg::*;

  localparam int TW    = VALUE_WIDTH + 2;
  localparam int NW    = VALUE_WIDTH + 3;
  localparam int OUT_W = ((VALUE_WIDTH + 8) / 8) * 8;

  logic                 adv;
  logic [VALUE_WIDTH:0] distance;
  logic                 table_empty;
  logic                 overflowed;
  logic                 total_saturated;

  stq_ctl_t      ctl_w  [TABLE_DEPTH+1];
  logic [TW-1:0] a_w    [TABLE_DEPTH+1];
  logic [NW-1:0] nt_w   [TABLE_DEPTH+1];
  logic [TW-1:0] best_w [TABLE_DEPTH+1];

  assign s_axis_tready = adv;

  // Running total, fill count and entry stages.
  stq_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_valid_i(s_axis_tvalid),
    .req_type_i(s_axis_tuser),
    .operand_i (s_axis_tdata[VALUE_WIDTH-1:0]),
    .ctl_o     (ctl_w[0]),
    .a_o       (a_w[0]),
    .nt_o      (nt_w[0]),
    .best_o    (best_w[0])
  );

  // Row of table cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    stq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .ctl_i (ctl_w[i]),
      .a_i   (a_w[i]),
      .nt_i  (nt_w[i]),
      .best_i(best_w[i]),
      .ctl_o (ctl_w[i+1]),
      .a_o   (a_w[i+1]),
      .nt_o  (nt_w[i+1]),
      .best_o(best_w[i+1])
    );
  end

  // Result register.
  stq_out #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_w[TABLE_DEPTH]),
    .best_i      (best_w[TABLE_DEPTH]),
    .ready_i     (m_axis_tready),
    .adv_o       (adv),
    .valid_o     (m_axis_tvalid),
    .distance_o  (distance),
    .empty_o     (table_empty),
    .overflowed_o(overflowed),
    .saturated_o (total_saturated)
  );

  assign m_axis_tdata = OUT_W'(distance);
  assign m_axis_tuser = {total_saturated, overflowed, table_empty};

endmodule
